### hw/rtl/bmalu_pkg.sv
// Package for the bit-manipulation ALU: opcode type, bit-group masks, the swap
// helper shared by the shuffle networks and the grev stage helper. No dependencies.
package bmalu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 4;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLMUL  = 4'd0,
    OP_CLMULH = 4'd1,
    OP_CLMULR = 4'd2,
    OP_ROR    = 4'd3,
    OP_ANDN   = 4'd4,
    OP_GREV   = 4'd5,
    OP_SHFL   = 4'd6,
    OP_UNSHFL = 4'd7,
    OP_PACK   = 4'd8,
    OP_PACKU  = 4'd9,
    OP_PACKH  = 4'd10
  } op_t;

  // Generalized reverse masks, one per control bit.
  localparam word_t GREV_M1  = 32'h5555_5555;
  localparam word_t GREV_M2  = 32'h3333_3333;
  localparam word_t GREV_M4  = 32'h0F0F_0F0F;
  localparam word_t GREV_M8  = 32'h00FF_00FF;
  localparam word_t GREV_M16 = 32'h0000_FFFF;

  // Shuffle stage masks: left group moves down, right group moves up.
  localparam word_t SHFL_L8 = 32'h00FF_0000;
  localparam word_t SHFL_R8 = 32'h0000_FF00;
  localparam word_t SHFL_L4 = 32'h0F00_0F00;
  localparam word_t SHFL_R4 = 32'h00F0_00F0;
  localparam word_t SHFL_L2 = 32'h3030_3030;
  localparam word_t SHFL_R2 = 32'h0C0C_0C0C;
  localparam word_t SHFL_L1 = 32'h4444_4444;
  localparam word_t SHFL_R1 = 32'h2222_2222;

  // Swaps the bit groups under the two masks, n places apart.
  function automatic word_t swap_stage(input word_t v, input word_t left,
                                       input word_t right, input int unsigned n);
    word_t keep;
    keep = v & ~(left | right);
    return keep | ((v << n) & left) | ((v >> n) & right);
  endfunction

  // Swaps adjacent groups of n bits where mask marks the low group.
  function automatic word_t grev_stage(input word_t v, input word_t mask,
                                       input int unsigned n);
    return ((v & mask) << n) | ((v & ~mask) >> n);
  endfunction

endpackage

### hw/rtl/bitmanip_alu_top.sv
// Top level of the bit-manipulation ALU: input register, datapath and result
// register with valid/stall handshakes. Depends on bmalu_pkg and bmalu_core.
//
//   Channel   Direction  Handshake             Word
//   in_       input      in_valid / in_stall   in_req_type, in_operand_a, in_operand_b
//   out_      output     out_valid / out_stall out_result
//
// An accepted word passes the input register and then the result register, where
// out_valid marks it; one word is accepted every cycle while the output is not
// stalled.
// The carry-less multiply tree between the two registers sets the clock limit.
// Reset (rst_n low, synchronous) empties both stages.
// A stalled output holds its word; the input stalls only when both stages are full.
module bitmanip_alu_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [3:0]             in_req_type,
  input  bmalu_pkg::word_t       in_operand_a,
  input  bmalu_pkg::word_t       in_operand_b,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bmalu_pkg::word_t       out_result
);
  import bmalu_pkg::*;

  logic  s1_valid_r, s1_valid_nxt;
  op_t   s1_op_r;
  word_t s1_a_r;
  word_t s1_b_r;
  logic  out_valid_r, out_valid_nxt;
  word_t out_result_r;
  word_t core_result;
  logic  s2_advance;
  logic  s1_load;

  assign s2_advance    = !out_valid_r || !out_stall;
  assign in_stall      = s1_valid_r && !s2_advance;
  assign s1_load       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = s2_advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op_r <= op_t'(in_req_type);
      s1_a_r  <= in_operand_a;
      s1_b_r  <= in_operand_b;
    end
    if (s2_advance && s1_valid_r) begin
      out_result_r <= core_result;
    end
  end

  bmalu_core u_core (
    .op     (s1_op_r),
    .a      (s1_a_r),
    .b      (s1_b_r),
    .result (core_result)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // A word in the first stage is never dropped while the output is blocked.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("first stage lost a word while the output was stalled");

  // The result register takes the datapath output whenever a word moves forward.
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_advance && s1_valid_r) |=> (out_valid_r && out_result_r == $past(core_result)))
    else $error("result register did not capture the datapath output");

  // A new output word only appears when the first stage held one.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !s1_valid_r) |=> !out_valid_r)
    else $error("output became valid with no word in the first stage");

  // The input side stalls only when both stages are occupied.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled while a stage was free");

endmodule

### hw/rtl/bmalu_core.sv
// Combinational datapath of the bit-manipulation ALU: carry-less multiply,
// rotate, and-not, reverse, shuffle and pack operations. Depends on bmalu_pkg.
module bmalu_core (
  input  bmalu_pkg::op_t   op,
  input  bmalu_pkg::word_t a,
  input  bmalu_pkg::word_t b,
  output bmalu_pkg::word_t result
);
  import bmalu_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W - 1;

  logic [PROD_W-1:0] prod;
  logic [2*DATA_W-1:0] rot_dbl;
  word_t ror_res;
  word_t grev_res;
  word_t shfl_res;
  word_t unshfl_res;
  logic [4:0] ctl;

  // Full carry-less product; each bit is the parity of its diagonal of
  // partial-product terms.
  always_comb begin
    logic [DATA_W-1:0] terms;
    for (int i = 0; i < PROD_W; i++) begin
      terms = '0;
      for (int j = 0; j < DATA_W; j++) begin
        if ((i - j) >= 0 && (i - j) < DATA_W) begin
          terms[j] = a[j] & b[i-j];
        end
      end
      prod[i] = ^terms;
    end
  end

  assign ctl     = b[4:0];
  assign rot_dbl = {a, a} >> ctl;
  assign ror_res = rot_dbl[DATA_W-1:0];

  always_comb begin
    word_t v;
    v = a;
    if (ctl[0]) v = grev_stage(v, GREV_M1, 1);
    if (ctl[1]) v = grev_stage(v, GREV_M2, 2);
    if (ctl[2]) v = grev_stage(v, GREV_M4, 4);
    if (ctl[3]) v = grev_stage(v, GREV_M8, 8);
    if (ctl[4]) v = grev_stage(v, GREV_M16, 16);
    grev_res = v;
  end

  // Shuffle runs the stages coarse to fine; unshuffle runs them in reverse.
  always_comb begin
    word_t v;
    v = a;
    if (ctl[3]) v = swap_stage(v, SHFL_L8, SHFL_R8, 8);
    if (ctl[2]) v = swap_stage(v, SHFL_L4, SHFL_R4, 4);
    if (ctl[1]) v = swap_stage(v, SHFL_L2, SHFL_R2, 2);
    if (ctl[0]) v = swap_stage(v, SHFL_L1, SHFL_R1, 1);
    shfl_res = v;
  end

  always_comb begin
    word_t v;
    v = a;
    if (ctl[0]) v = swap_stage(v, SHFL_L1, SHFL_R1, 1);
    if (ctl[1]) v = swap_stage(v, SHFL_L2, SHFL_R2, 2);
    if (ctl[2]) v = swap_stage(v, SHFL_L4, SHFL_R4, 4);
    if (ctl[3]) v = swap_stage(v, SHFL_L8, SHFL_R8, 8);
    unshfl_res = v;
  end

  always_comb begin
    unique case (op)
      OP_CLMUL:  result = prod[DATA_W-1:0];
      OP_CLMULH: result = {1'b0, prod[PROD_W-1:DATA_W]};
      OP_CLMULR: result = prod[PROD_W-1:DATA_W-1];
      OP_ROR:    result = ror_res;
      OP_ANDN:   result = a & ~b;
      OP_GREV:   result = grev_res;
      OP_SHFL:   result = shfl_res;
      OP_UNSHFL: result = unshfl_res;
      OP_PACK:   result = {b[15:0], a[15:0]};
      OP_PACKU:  result = {b[31:16], a[31:16]};
      OP_PACKH:  result = {16'h0000, b[7:0], a[7:0]};
      default:   result = '0;
    endcase
  end

endmodule
